// ----- design/atm_pkg.sv -----
// Package for the address/type memo table: table geometry, hash constant,
// codes and the state machine type. No dependencies.
package atm_pkg;

  // Table geometry. TABLE_SLOTS must be a power of two.
  localparam int unsigned TABLE_SLOTS = 4096;
  localparam int unsigned SLOT_W      = $clog2(TABLE_SLOTS);
  localparam int unsigned CNT_W       = SLOT_W + 1;
  localparam int unsigned HALF_SLOTS  = TABLE_SLOTS / 2;
  // Live slots sit in the lower half of each memory, the survivor list of
  // a forget in the upper half.
  localparam int unsigned MEM_DEPTH   = 2 * TABLE_SLOTS;
  localparam int unsigned MEM_AW      = SLOT_W + 1;

  localparam logic [31:0] HASH_MULT = 32'h9E3779B1;

  typedef enum logic [1:0] {
    MODE_PROBE  = 2'd0,
    MODE_STORE  = 2'd1,
    MODE_FORGET = 2'd2,
    MODE_CLEAR  = 2'd3
  } mode_e;

  typedef enum logic [1:0] {
    STATUS_DONE   = 2'd0,
    STATUS_FULL   = 2'd1,
    STATUS_WEDGED = 2'd2,
    STATUS_NULL   = 2'd3
  } status_e;

  // Where a clearing sweep continues.
  typedef enum logic [1:0] {
    AFTER_IDLE,
    AFTER_RESP,
    AFTER_REINS
  } after_e;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_HASH,
    ST_PRD,
    ST_PCHK,
    ST_FRD,
    ST_FSCAN,
    ST_CLR,
    ST_RRD,
    ST_RLOAD,
    ST_RESP
  } state_e;

  // Key word of one slot.
  typedef struct packed {
    logic        valid;
    logic [31:0] addr;
    logic [8:0]  ktype;
  } key_ent_t;

endpackage

// ----- design/atm_if.sv -----
// Channel interfaces of the memo table: request and result, each with a
// valid/ready handshake. No dependencies.
interface atm_in_if;
  logic        valid;
  logic        ready;
  logic [1:0]  mode;
  logic [31:0] key_address;
  logic [8:0]  key_type;
  logic [11:0] slot_select;
  logic [63:0] new_value;
  logic [31:0] range_size;

  modport source (output valid, mode, key_address, key_type, slot_select, new_value,
                  range_size, input ready);
  modport sink   (input valid, mode, key_address, key_type, slot_select, new_value,
                  range_size, output ready);
endinterface

interface atm_out_if;
  logic        valid;
  logic        ready;
  logic [1:0]  status;
  logic        hit;
  logic [11:0] slot_index;
  logic [63:0] slot_value;
  logic [12:0] entry_count;

  modport source (output valid, status, hit, slot_index, slot_value, entry_count,
                  input ready);
  modport sink   (input valid, status, hit, slot_index, slot_value, entry_count,
                  output ready);
endinterface

// ----- design/atm_hash.sv -----
// Home slot hash of the memo table, registered at its output.
// Depends on atm_pkg.
module atm_hash (
  input  logic        clk_i,
  input  logic [31:0] addr_i,
  input  logic [8:0]  ktype_i,
  output logic [atm_pkg::SLOT_W-1:0] home_o
);
  import atm_pkg::*;

  logic [31:0] prod;
  logic [31:0] mix;
  logic [SLOT_W-1:0] home_q;

  // Multiply by the golden-ratio constant, fold the upper half down, mask.
  always_comb begin
    prod = 32'(32'(ktype_i) * HASH_MULT);
    mix  = addr_i ^ prod;
    mix  = mix ^ (mix >> 16);
  end

  always_ff @(posedge clk_i) begin
    home_q <= mix[SLOT_W-1:0];
  end

  assign home_o = home_q;

endmodule

// ----- design/address_type_memo_table_top.sv -----
// Top level of the address/type memo table: open addressing with linear
// probing, kept in a key memory and a handle memory.
// Depends on atm_pkg, atm_if.sv and atm_hash.
//
//   port   | role   | carries
//   in_i   | sink   | mode, key_address, key_type, slot_select, new_value, range_size
//   out_o  | source | status, hit, slot_index, slot_value, entry_count
//
// A probe passes through accept, hash, first read, one check per slot walked
// and result. Store goes from accept straight to its result. Clear sweeps
// all TABLE_SLOTS slots, then gives its result. Forget scans the table into
// the survivor list, runs a clearing sweep, then reinserts each survivor by a
// probe walk. After reset a clearing sweep over all slots runs before input.
// A finished result waits in the output register; the next item is accepted
// meanwhile and holds in its result state until the register frees up.
module address_type_memo_table_top (
  input  logic clk_i,
  input  logic rst_ni,
  atm_in_if.sink    in_i,
  atm_out_if.source out_o
);
  import atm_pkg::*;

  state_e state_q, state_d;
  after_e after_q;

  logic [1:0]  mode_q;
  logic [31:0] addr_q;
  logic [8:0]  type_q;
  logic [31:0] size_q;
  logic [63:0] hv_q;
  logic        reins_q;
  logic [SLOT_W-1:0] idx_q;
  logic [SLOT_W-1:0] n_q;
  logic [SLOT_W-1:0] scan_q;
  logic [CNT_W-1:0]  kept_q;
  logic [CNT_W-1:0]  rk_q;
  logic [CNT_W-1:0]  count_q;

  logic [1:0]  r_status_q;
  logic        r_hit_q;
  logic [11:0] r_idx_q;
  logic [63:0] r_value_q;

  logic        out_valid_q;
  logic [1:0]  out_status_q;
  logic        out_hit_q;
  logic [11:0] out_idx_q;
  logic [63:0] out_value_q;
  logic [12:0] out_count_q;

  logic [SLOT_W-1:0] home;

  // Memories with a registered read port.
  key_ent_t    key_mem [MEM_DEPTH];
  logic [63:0] hdl_mem [MEM_DEPTH];
  key_ent_t    key_rd;
  logic [63:0] hdl_rd;

  logic [MEM_AW-1:0] raddr;
  logic              key_we;
  logic [MEM_AW-1:0] key_waddr;
  key_ent_t          key_wdata;
  logic              hdl_we;
  logic [MEM_AW-1:0] hdl_waddr;
  logic [63:0]       hdl_wdata;

  logic in_acc;
  logic sel_in_range;
  logic slot_free;
  logic slot_match;
  logic tbl_full;
  logic probe_last;
  logic probe_end;
  logic scan_last;
  logic survive;
  logic resp_go;

  atm_hash u_hash (
    .clk_i   (clk_i),
    .addr_i  (addr_q),
    .ktype_i (type_q),
    .home_o  (home)
  );

  // Decisions shared by the state machine and the datapath.
  always_comb begin
    in_acc       = in_i.valid && (state_q == ST_IDLE);
    sel_in_range = 32'(in_i.slot_select) < 32'(TABLE_SLOTS);
    slot_free    = !key_rd.valid;
    slot_match   = key_rd.valid && (key_rd.addr == addr_q) && (key_rd.ktype == type_q);
    tbl_full     = count_q >= CNT_W'(HALF_SLOTS);
    probe_last   = n_q == SLOT_W'(TABLE_SLOTS - 1);
    probe_end    = slot_free || slot_match || probe_last;
    scan_last    = scan_q == SLOT_W'(TABLE_SLOTS - 1);
    survive      = key_rd.valid &&
                   !((key_rd.addr >= addr_q) &&
                     ({1'b0, key_rd.addr} < ({1'b0, addr_q} + {1'b0, size_q})));
    resp_go      = !out_valid_q || out_o.ready;
  end

  assign in_i.ready = (state_q == ST_IDLE);

  // Next state.
  always_comb begin
    state_d = state_q;
    case (state_q)
      ST_IDLE: begin
        if (in_acc) begin
          case (mode_e'(in_i.mode))
            MODE_PROBE:  state_d = (in_i.key_address == '0) ? ST_RESP : ST_HASH;
            MODE_STORE:  state_d = ST_RESP;
            MODE_FORGET: state_d = (in_i.key_address == '0 || in_i.range_size == '0)
                                   ? ST_RESP : ST_FRD;
            default:     state_d = ST_CLR;
          endcase
        end
      end
      ST_HASH:  state_d = ST_PRD;
      ST_PRD:   state_d = ST_PCHK;
      ST_PCHK: begin
        if (probe_end) state_d = reins_q ? ST_RRD : ST_RESP;
      end
      ST_FRD:   state_d = ST_FSCAN;
      ST_FSCAN: begin
        if (scan_last) state_d = ST_CLR;
      end
      ST_CLR: begin
        if (scan_last) begin
          case (after_q)
            AFTER_IDLE:  state_d = ST_IDLE;
            AFTER_RESP:  state_d = ST_RESP;
            default:     state_d = ST_RRD;
          endcase
        end
      end
      ST_RRD:   state_d = (rk_q == kept_q) ? ST_RESP : ST_RLOAD;
      ST_RLOAD: state_d = ST_HASH;
      ST_RESP: begin
        if (resp_go) state_d = ST_IDLE;
      end
      default:  state_d = ST_IDLE;
    endcase
  end

  // Memory addresses and write strobes.
  always_comb begin
    raddr     = '0;
    key_we    = 1'b0;
    key_waddr = '0;
    key_wdata = '0;
    hdl_we    = 1'b0;
    hdl_waddr = '0;
    hdl_wdata = '0;
    case (state_q)
      ST_IDLE: begin
        if (in_acc && mode_e'(in_i.mode) == MODE_STORE && sel_in_range) begin
          hdl_we    = 1'b1;
          hdl_waddr = {1'b0, SLOT_W'(in_i.slot_select)};
          hdl_wdata = in_i.new_value;
        end
      end
      ST_PRD:  raddr = {1'b0, home};
      ST_PCHK: begin
        raddr = {1'b0, idx_q + SLOT_W'(1)};
        if (slot_free && !tbl_full) begin
          key_we    = 1'b1;
          key_waddr = {1'b0, idx_q};
          key_wdata = '{valid: 1'b1, addr: addr_q, ktype: type_q};
          hdl_we    = 1'b1;
          hdl_waddr = {1'b0, idx_q};
          hdl_wdata = reins_q ? hv_q : '0;
        end else if (slot_match && reins_q) begin
          hdl_we    = 1'b1;
          hdl_waddr = {1'b0, idx_q};
          hdl_wdata = hv_q;
        end
      end
      ST_FRD:  raddr = {1'b0, scan_q};
      ST_FSCAN: begin
        raddr = {1'b0, scan_q + SLOT_W'(1)};
        if (survive) begin
          key_we    = 1'b1;
          key_waddr = {1'b1, kept_q[SLOT_W-1:0]};
          key_wdata = key_rd;
          hdl_we    = 1'b1;
          hdl_waddr = {1'b1, kept_q[SLOT_W-1:0]};
          hdl_wdata = hdl_rd;
        end
      end
      ST_CLR: begin
        key_we    = 1'b1;
        key_waddr = {1'b0, scan_q};
        key_wdata = '0;
      end
      ST_RRD:  raddr = {1'b1, rk_q[SLOT_W-1:0]};
      default: raddr = '0;
    endcase
  end

  // Key and handle memories.
  always_ff @(posedge clk_i) begin
    if (key_we) key_mem[key_waddr] <= key_wdata;
    key_rd <= key_mem[raddr];
  end

  always_ff @(posedge clk_i) begin
    if (hdl_we) hdl_mem[hdl_waddr] <= hdl_wdata;
    hdl_rd <= hdl_mem[raddr];
  end

  // Control registers and counters.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_CLR;
      after_q     <= AFTER_IDLE;
      scan_q      <= '0;
      count_q     <= '0;
      kept_q      <= '0;
      rk_q        <= '0;
      reins_q     <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      state_q <= state_d;
      case (state_q)
        ST_IDLE: begin
          if (in_acc) begin
            scan_q  <= '0;
            kept_q  <= '0;
            rk_q    <= '0;
            reins_q <= 1'b0;
            after_q <= (mode_e'(in_i.mode) == MODE_FORGET) ? AFTER_REINS : AFTER_RESP;
          end
        end
        ST_PCHK: begin
          if (slot_free && !tbl_full) count_q <= count_q + CNT_W'(1);
          if (probe_end && reins_q) rk_q <= rk_q + CNT_W'(1);
        end
        ST_FSCAN: begin
          if (survive) kept_q <= kept_q + CNT_W'(1);
          scan_q <= scan_q + SLOT_W'(1);
        end
        ST_CLR: begin
          scan_q <= scan_q + SLOT_W'(1);
          if (scan_last) count_q <= '0;
        end
        ST_RLOAD: reins_q <= 1'b1;
        default: ;
      endcase
      // Output register: load a result, or drop it once transferred.
      if (state_q == ST_RESP && resp_go) begin
        out_valid_q <= 1'b1;
      end else if (out_o.ready) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  // Payload registers.
  always_ff @(posedge clk_i) begin
    case (state_q)
      ST_IDLE: begin
        if (in_acc) begin
          mode_q  <= in_i.mode;
          addr_q  <= in_i.key_address;
          type_q  <= in_i.key_type;
          size_q  <= in_i.range_size;
          r_hit_q <= 1'b0;
          r_status_q <= ((mode_e'(in_i.mode) == MODE_PROBE ||
                          mode_e'(in_i.mode) == MODE_FORGET) && in_i.key_address == '0)
                        ? STATUS_NULL : STATUS_DONE;
          r_idx_q   <= (mode_e'(in_i.mode) == MODE_STORE) ? in_i.slot_select : '0;
          r_value_q <= (mode_e'(in_i.mode) == MODE_STORE && sel_in_range)
                       ? in_i.new_value : '0;
        end
      end
      ST_PRD: begin
        idx_q <= home;
        n_q   <= '0;
      end
      ST_PCHK: begin
        if (!reins_q && mode_e'(mode_q) == MODE_PROBE) begin
          if (slot_free) begin
            if (tbl_full) begin
              r_status_q <= STATUS_FULL;
            end else begin
              r_idx_q <= 12'(idx_q);
            end
          end else if (slot_match) begin
            r_hit_q   <= 1'b1;
            r_idx_q   <= 12'(idx_q);
            r_value_q <= hdl_rd;
          end else if (probe_last) begin
            r_status_q <= STATUS_WEDGED;
          end
        end
        idx_q <= idx_q + SLOT_W'(1);
        n_q   <= n_q + SLOT_W'(1);
      end
      ST_RLOAD: begin
        addr_q <= key_rd.addr;
        type_q <= key_rd.ktype;
        hv_q   <= hdl_rd;
      end
      ST_RESP: begin
        if (resp_go) begin
          out_status_q <= r_status_q;
          out_hit_q    <= r_hit_q;
          out_idx_q    <= r_idx_q;
          out_value_q  <= r_value_q;
          out_count_q  <= 13'(count_q);
        end
      end
      default: ;
    endcase
  end

  assign out_o.valid       = out_valid_q;
  assign out_o.status      = out_status_q;
  assign out_o.hit         = out_hit_q;
  assign out_o.slot_index  = out_idx_q;
  assign out_o.slot_value  = out_value_q;
  assign out_o.entry_count = out_count_q;

endmodule
